// ===== sv/ctfp_pkg.sv =====
// Package for the conic-through-five-points unit: widths, types, coefficient codes.
// Depends on nothing.
`default_nettype none
package ctfp_pkg;
	localparam int FIELD_BITS = 12;
	localparam int LINE_BITS  = 32;
	localparam int COEF_BITS  = 64;
	localparam int VAL_BITS   = 64;
	localparam int NUM_BITS   = 128;
	localparam int DEN_BITS   = 61;
	localparam int IDX_BITS   = 3;

	typedef enum logic [IDX_BITS-1:0] {
		COEF_A  = 3'd0,
		COEF_2B = 3'd1,
		COEF_C  = 3'd2,
		COEF_2D = 3'd3,
		COEF_2E = 3'd4,
		COEF_F  = 3'd5
	} coef_idx_t;

	typedef logic signed [LINE_BITS-1:0] line_val_t;
	typedef logic signed [COEF_BITS-1:0] coef_val_t;

	typedef struct packed {
		line_val_t a;
		line_val_t b;
		line_val_t c;
	} line_t;

	typedef struct packed {
		coef_val_t k0;
		coef_val_t k1;
		coef_val_t k2;
		coef_val_t k3;
		coef_val_t k4;
		coef_val_t k5;
	} conic_t;

	// Coefficient k of a conic, selected by index.
	function automatic coef_val_t coef_sel(input conic_t c, input coef_idx_t i);
		coef_val_t r;
		r = c.k0;
		unique case (i)
			COEF_A:  r = c.k0;
			COEF_2B: r = c.k1;
			COEF_C:  r = c.k2;
			COEF_2D: r = c.k3;
			COEF_2E: r = c.k4;
			COEF_F:  r = c.k5;
			default: r = c.k5;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== sv/conic_through_five_points_unit.sv =====
// Top level of the conic-through-five-points unit: front pipeline and
// coefficient streamer. Depends on ctfp_pkg, ctfp_front, ctfp_back.
// An item is taken when start is high and busy low. Each item yields six
// results, one per cycle, coefficient index 0 to 5, flagged by strobe; the
// receiver cannot stall. The result channel sets the rate: six words per item,
// so busy stays high after each accept and holds off the next item until its
// words can follow the last word of this one with no gap; items overlap in
// the pipeline. The first word of an item passes the four front stages, the
// coefficient sequencer, two product stages and the output register. All
// products are built from multipliers of about 32x32 bits.
`default_nettype none
module conic_through_five_points_unit #(
	parameter int COORD_BITS = 12
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire logic operation,
	input  wire logic [11:0] ax, ay, bx, by, cx, cy, ddx, ddy, ex, ey,
	output logic strobe,
	output logic [2:0] coefficient_index,
	output logic signed [63:0] value_high,
	output logic [63:0] value_low,
	output logic signed [60:0] denominator,
	output logic degenerate,
	output logic last
);
	logic accept, fvalid;
	logic [2:0] gap_q;
	ctfp_pkg::conic_t c0, c1;
	ctfp_pkg::coef_val_t v0, v1;

	assign accept = start && !busy;

	// Accept spacing: each item loads the streamer as it issues the last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) gap_q <= 3'd0;
		else if (accept) gap_q <= 3'd5;
		else if (gap_q != 3'd0) gap_q <= gap_q - 3'd1;
	end
	assign busy = (gap_q != 3'd0);

	ctfp_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk, .arst_n, .in_valid(accept), .operation,
		.ax, .ay, .bx, .by, .cx, .cy, .ddx, .ddy, .ex, .ey,
		.valid_s4(fvalid), .c0_s4(c0), .c1_s4(c1), .v0_s4(v0), .v1_s4(v1)
	);

	ctfp_back u_back (
		.clk, .arst_n, .load(fvalid), .c0, .c1, .v0, .v1,
		.strobe, .coefficient_index, .value_high, .value_low,
		.denominator, .degenerate, .last
	);
endmodule
`default_nettype wire

// ===== sv/ctfp_front.sv =====
// Front stages: coordinates to lines, lines to two line-pair conics, and their
// values at the last point. Depends on ctfp_pkg.
`default_nettype none
module ctfp_front #(
	parameter int COORD_BITS = 12
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic operation,
	input  wire logic [ctfp_pkg::FIELD_BITS-1:0] ax, ay, bx, by, cx, cy, ddx, ddy, ex, ey,
	output logic valid_s4,
	output ctfp_pkg::conic_t c0_s4,
	output ctfp_pkg::conic_t c1_s4,
	output ctfp_pkg::coef_val_t v0_s4,
	output ctfp_pkg::coef_val_t v1_s4
);
	typedef logic signed [ctfp_pkg::LINE_BITS-1:0] lv_t;
	typedef logic signed [ctfp_pkg::COEF_BITS-1:0] cv_t;

	// Low COORD_BITS, sign-extended.
	function automatic lv_t crd(input logic [ctfp_pkg::FIELD_BITS-1:0] r);
		logic signed [COORD_BITS-1:0] t;
		t = r[COORD_BITS-1:0];
		return lv_t'(t);
	endfunction

	function automatic ctfp_pkg::line_t mk_line(input lv_t x0, input lv_t y0,
			input lv_t x1, input lv_t y1);
		ctfp_pkg::line_t l;
		l.a = y1 - y0;
		l.b = x0 - x1;
		l.c = x1 * y0 - x0 * y1;
		return l;
	endfunction

	function automatic ctfp_pkg::conic_t lprod(input ctfp_pkg::line_t p,
			input ctfp_pkg::line_t q);
		ctfp_pkg::conic_t c;
		c.k0 = cv_t'(p.a) * cv_t'(q.a);
		c.k1 = cv_t'(p.a) * cv_t'(q.b) + cv_t'(p.b) * cv_t'(q.a);
		c.k2 = cv_t'(p.b) * cv_t'(q.b);
		c.k3 = cv_t'(p.a) * cv_t'(q.c) + cv_t'(p.c) * cv_t'(q.a);
		c.k4 = cv_t'(p.b) * cv_t'(q.c) + cv_t'(p.c) * cv_t'(q.b);
		c.k5 = cv_t'(p.c) * cv_t'(q.c);
		return c;
	endfunction

	// Line value at a point; fits well inside the line width
	function automatic lv_t lval(input ctfp_pkg::line_t l, input lv_t x, input lv_t y);
		return l.a * x + l.b * y + l.c;
	endfunction

	lv_t xa, ya, xb, yb, xc, yc, xd, yd;
	ctfp_pkg::line_t l0, l1, l2, l3;

	// Stage 1: lines and last point
	logic valid_s1;
	ctfp_pkg::line_t l0_s1, l1_s1, l2_s1, l3_s1;
	lv_t px_s1, py_s1;

	always_comb begin
		xa = crd(ax); ya = crd(ay); xb = crd(bx); yb = crd(by);
		xc = crd(cx); yc = crd(cy); xd = crd(ddx); yd = crd(ddy);
		if (!operation) begin
			l0 = mk_line(xa, ya, xb, yb);
			l1 = mk_line(xb, yb, xc, yc);
			l2 = mk_line(xc, yc, xd, yd);
			l3 = mk_line(xd, yd, xa, ya);
		end else begin
			// tangent mode: C0 = T1*T2 (l0*l2), C1 = K*K (l1*l3)
			l0 = mk_line(xa, ya, xa + xb, ya + yb);
			l2 = mk_line(xc, yc, xc + xd, yc + yd);
			l1 = mk_line(xa, ya, xc, yc);
			l3 = l1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else valid_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		l0_s1 <= l0; l1_s1 <= l1; l2_s1 <= l2; l3_s1 <= l3;
		px_s1 <= crd(ex); py_s1 <= crd(ey);
	end

	// Stage 2: line products and each line's value at the last point
	logic valid_s2;
	ctfp_pkg::conic_t c0_s2, c1_s2;
	lv_t e0_s2, e1_s2, e2_s2, e3_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else valid_s2 <= valid_s1;
	end
	always_ff @(posedge clk) begin
		c0_s2 <= lprod(l0_s1, l2_s1);
		c1_s2 <= lprod(l1_s1, l3_s1);
		e0_s2 <= lval(l0_s1, px_s1, py_s1);
		e1_s2 <= lval(l1_s1, px_s1, py_s1);
		e2_s2 <= lval(l2_s1, px_s1, py_s1);
		e3_s2 <= lval(l3_s1, px_s1, py_s1);
	end

	// Stage 3: a line-pair conic at a point is the product of its two line values
	logic valid_s3;
	ctfp_pkg::conic_t c0_s3, c1_s3;
	cv_t v0_s3, v1_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s3 <= 1'b0;
		else valid_s3 <= valid_s2;
	end
	always_ff @(posedge clk) begin
		c0_s3 <= c0_s2; c1_s3 <= c1_s2;
		v0_s3 <= cv_t'(e0_s2) * cv_t'(e2_s2);
		v1_s3 <= cv_t'(e1_s2) * cv_t'(e3_s2);
	end

	// Stage 4: output register toward the streamer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s4 <= 1'b0;
		else valid_s4 <= valid_s3;
	end
	always_ff @(posedge clk) begin
		c0_s4 <= c0_s3; c1_s4 <= c1_s3;
		v0_s4 <= v0_s3;
		v1_s4 <= v1_s3;
	end
endmodule
`default_nettype wire

// ===== sv/ctfp_back.sv =====
// Back stages: holds one item's conics and streams six 128-bit numerators.
// Depends on ctfp_pkg.
`default_nettype none
module ctfp_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic load,
	input  wire ctfp_pkg::conic_t c0,
	input  wire ctfp_pkg::conic_t c1,
	input  wire ctfp_pkg::coef_val_t v0,
	input  wire ctfp_pkg::coef_val_t v1,
	output logic strobe,
	output logic [ctfp_pkg::IDX_BITS-1:0] coefficient_index,
	output logic signed [ctfp_pkg::VAL_BITS-1:0] value_high,
	output logic [ctfp_pkg::VAL_BITS-1:0] value_low,
	output logic signed [ctfp_pkg::DEN_BITS-1:0] denominator,
	output logic degenerate,
	output logic last
);
	typedef logic signed [ctfp_pkg::NUM_BITS-1:0] nv_t;

	logic active_q;
	ctfp_pkg::coef_idx_t idx_q;
	ctfp_pkg::conic_t c0_q, c1_q;
	ctfp_pkg::coef_val_t v0_q, v1_q;

	// Coefficient sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= ctfp_pkg::COEF_A;
		end else if (load) begin
			active_q <= 1'b1;
			idx_q    <= ctfp_pkg::COEF_A;
		end else if (active_q) begin
			if (idx_q == ctfp_pkg::COEF_F) active_q <= 1'b0;
			else idx_q <= ctfp_pkg::coef_idx_t'(idx_q + 3'd1);
		end
	end
	always_ff @(posedge clk) begin
		if (load) begin
			c0_q <= c0; c1_q <= c1; v0_q <= v0; v1_q <= v1;
		end
	end

	// Coefficients of the current index
	logic va_s1, lst_s1;
	logic [ctfp_pkg::IDX_BITS-1:0] idx_s1;
	ctfp_pkg::coef_val_t k0, k1;
	always_comb begin
		k0 = ctfp_pkg::coef_sel(c0_q, idx_q);
		k1 = ctfp_pkg::coef_sel(c1_q, idx_q);
	end

	// Stage 1: 32x32 partial products of k0*v1 (a) and k1*v0 (b)
	logic [63:0] ll_a_s1, ll_b_s1;
	logic signed [64:0] lh_a_s1, hl_a_s1, lh_b_s1, hl_b_s1;
	logic signed [63:0] hh_a_s1, hh_b_s1;
	logic signed [64:0] den_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) va_s1 <= 1'b0;
		else va_s1 <= active_q;
	end
	always_ff @(posedge clk) begin
		idx_s1  <= idx_q;
		lst_s1  <= (idx_q == ctfp_pkg::COEF_F);
		ll_a_s1 <= k0[31:0] * v1_q[31:0];
		lh_a_s1 <= $signed({1'b0, k0[31:0]}) * $signed(v1_q[63:32]);
		hl_a_s1 <= $signed(k0[63:32]) * $signed({1'b0, v1_q[31:0]});
		hh_a_s1 <= $signed(k0[63:32]) * $signed(v1_q[63:32]);
		ll_b_s1 <= k1[31:0] * v0_q[31:0];
		lh_b_s1 <= $signed({1'b0, k1[31:0]}) * $signed(v0_q[63:32]);
		hl_b_s1 <= $signed(k1[63:32]) * $signed({1'b0, v0_q[31:0]});
		hh_b_s1 <= $signed(k1[63:32]) * $signed(v0_q[63:32]);
		den_s1  <= 65'(v1_q) - 65'(v0_q);
	end

	// Stage 2: combine partials into the two full products
	logic va_s2, lst_s2;
	logic [ctfp_pkg::IDX_BITS-1:0] idx_s2;
	logic signed [64:0] den_s2;
	nv_t p1_s2, p2_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) va_s2 <= 1'b0;
		else va_s2 <= va_s1;
	end
	always_ff @(posedge clk) begin
		idx_s2 <= idx_s1; lst_s2 <= lst_s1; den_s2 <= den_s1;
		p1_s2  <= (nv_t'({64'd0, ll_a_s1}) + (nv_t'(lh_a_s1) <<< 32)) +
			((nv_t'(hl_a_s1) <<< 32) + (nv_t'(hh_a_s1) <<< 64));
		p2_s2  <= (nv_t'({64'd0, ll_b_s1}) + (nv_t'(lh_b_s1) <<< 32)) +
			((nv_t'(hl_b_s1) <<< 32) + (nv_t'(hh_b_s1) <<< 64));
	end

	// Stage 3: difference to output register
	nv_t num;
	assign num = p1_s2 - p2_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) strobe <= 1'b0;
		else strobe <= va_s2;
	end
	always_ff @(posedge clk) begin
		coefficient_index <= idx_s2;
		value_high  <= num[127:64];
		value_low   <= num[63:0];
		denominator <= den_s2[ctfp_pkg::DEN_BITS-1:0];
		degenerate  <= (den_s2[63:0] == 64'd0);
		last        <= lst_s2;
	end
endmodule
`default_nettype wire

// ===== sv/ctfp_checker.sv =====
// Port-level checker for the conic unit, bound to the top level.
// Depends on conic_through_five_points_unit ports only.
`default_nettype none
module ctfp_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic strobe,
	input wire logic [2:0] coefficient_index,
	input wire logic last,
	input wire logic degenerate,
	input wire logic signed [60:0] denominator
);
	// last marks only the final coefficient
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (last == (coefficient_index == 3'd5))) else $error("last mismatch");
	// words of an item come in index order
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe && coefficient_index == $past(coefficient_index) + 3'd1)
		else $error("index gap");
	// denominator constant within an item
	a_den: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && coefficient_index != 3'd0 |-> $stable(denominator))
		else $error("denominator changed");
	// degenerate flags a zero denominator
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (degenerate == (denominator == 61'd0))) else $error("degenerate flag");
	// an accepted item keeps the unit busy next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised");
endmodule

bind conic_through_five_points_unit ctfp_checker u_ctfp_checker (
	.clk, .arst_n, .start, .busy, .strobe, .coefficient_index, .last, .degenerate,
	.denominator
);
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking bench for conic_through_five_points_unit: directed table, then random items.
// Depends on ctfp_pkg and the unit; predicts each word's numerator in 128-bit signed math.
`default_nettype none
module tb_top;
	localparam int LIMIT = 400000;

	typedef struct {
		logic [2:0] idx;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [60:0] den;
		logic degen;
		logic lst;
	} coef_word_t;

	typedef struct {
		logic op;
		logic [11:0] c [10];
		bit fixed;      // expected value typed in
		logic degen;    // typed degenerate flag
		logic [60:0] den;
	} stim_row_t;

	logic clk = 0, arst_n = 0, start = 0, operation = 0;
	logic [11:0] ax = 0, ay = 0, bx = 0, by = 0, cx = 0, cy = 0;
	logic [11:0] ddx = 0, ddy = 0, ex = 0, ey = 0;
	logic busy, strobe, degenerate, last;
	logic [2:0] coefficient_index;
	logic signed [63:0] value_high;
	logic [63:0] value_low;
	logic signed [60:0] denominator;

	coef_word_t expected_words[$];
	int errors = 0;
	int cycles = 0;
	stim_row_t rows[$];

	conic_through_five_points_unit DUT (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic report(input string what);
		errors++;
		$display("mismatch at cycle %0d: %s", cycles, what);
	endtask

	// Line through two points, product of two lines, conic value
	function automatic void line_of(input longint x0, y0, x1, y1, output longint l[3]);
		l[0] = y1 - y0;
		l[1] = x0 - x1;
		l[2] = x1 * y0 - x0 * y1;
	endfunction

	function automatic void pair_of(input longint p[3], q[3], output longint k[6]);
		k[0] = p[0] * q[0];
		k[1] = p[0] * q[1] + p[1] * q[0];
		k[2] = p[1] * q[1];
		k[3] = p[0] * q[2] + p[2] * q[0];
		k[4] = p[1] * q[2] + p[2] * q[1];
		k[5] = p[2] * q[2];
	endfunction

	function automatic longint eval_at(input longint k[6], input longint x, y);
		return k[0]*x*x + k[1]*x*y + k[2]*y*y + k[3]*x + k[4]*y + k[5];
	endfunction

	// Expected six words of one item
	task automatic predict_conic(input logic op, input logic [11:0] c [10]);
		longint v [10];
		longint l0[3], l1[3], l2[3], l3[3], k0[6], k1[6];
		longint e0, e1, dn;
		logic signed [127:0] num;
		coef_word_t w;
		for (int i = 0; i < 10; i++)
			v[i] = longint'($signed(c[i]));
		if (!op) begin
			line_of(v[0], v[1], v[2], v[3], l0);
			line_of(v[2], v[3], v[4], v[5], l1);
			line_of(v[4], v[5], v[6], v[7], l2);
			line_of(v[6], v[7], v[0], v[1], l3);
			pair_of(l0, l2, k0);
			pair_of(l1, l3, k1);
		end else begin
			line_of(v[0], v[1], v[0] + v[2], v[1] + v[3], l0);
			line_of(v[4], v[5], v[4] + v[6], v[5] + v[7], l1);
			line_of(v[0], v[1], v[4], v[5], l2);
			pair_of(l0, l1, k0);
			pair_of(l2, l2, k1);
		end
		e0 = eval_at(k0, v[8], v[9]);
		e1 = eval_at(k1, v[8], v[9]);
		dn = e1 - e0;
		for (int k = 0; k < 6; k++) begin
			num = 128'(signed'(e1)) * 128'(signed'(k0[k]))
				- 128'(signed'(e0)) * 128'(signed'(k1[k]));
			w.idx = 3'(k);
			w.hi = num[127:64];
			w.lo = num[63:0];
			w.den = dn[60:0];
			w.degen = (dn == 0);
			w.lst = (k == ctfp_pkg::COEF_F);
			expected_words.push_back(w);
		end
	endtask

	// Compare each strobed word with the oldest expectation
	always @(posedge clk) begin
		coef_word_t w;
		if (arst_n && strobe) begin
			if (expected_words.size() == 0)
				report("word with nothing expected");
			else begin
				w = expected_words.pop_front();
				if (coefficient_index !== w.idx) report("coefficient_index");
				if (value_high !== w.hi) report("value_high");
				if (value_low !== w.lo) report("value_low");
				if (denominator !== w.den) report("denominator");
				if (degenerate !== w.degen) report("degenerate");
				if (last !== w.lst) report("last");
			end
		end
	end

	// start stays high into the next item when there is no idle gap
	task automatic send_item(input logic op, input logic [11:0] c [10]);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		operation <= op;
		{ax, ay, bx, by, cx, cy, ddx, ddy, ex, ey} <=
			{c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], c[9]};
		start <= 1;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_conic(op, c);
	endtask

	function automatic stim_row_t make_row(input logic op, input int a0, a1, a2, a3, a4,
		input int a5, a6, a7, a8, a9);
		stim_row_t r;
		r.op = op;
		r.c[0] = 12'(a0); r.c[1] = 12'(a1); r.c[2] = 12'(a2); r.c[3] = 12'(a3);
		r.c[4] = 12'(a4); r.c[5] = 12'(a5); r.c[6] = 12'(a6); r.c[7] = 12'(a7);
		r.c[8] = 12'(a8); r.c[9] = 12'(a9);
		r.fixed = 0; r.degen = 0; r.den = 0;
		return r;
	endfunction

	function automatic int rc(input int span);
		return int'($urandom_range(0, 2*span)) - span;
	endfunction

	initial begin
		stim_row_t r;
		logic [11:0] c [10];
		int mode;
		// all points at the origin: everything zero, flagged degenerate
		r = make_row(0, 0,0,0,0,0,0,0,0,0,0); r.fixed = 1; r.degen = 1; rows.push_back(r);
		r = make_row(1, 0,0,0,0,0,0,0,0,0,0); r.fixed = 1; r.degen = 1; rows.push_back(r);
		// fifth point equal to first: both pairs vanish there
		r = make_row(0, 3,1,-2,5,7,-4,0,9,3,1); r.fixed = 1; r.degen = 1; rows.push_back(r);
		rows.push_back(make_row(0, 0,0,1,0,1,1,0,1,2,3));
		rows.push_back(make_row(0, 2047,2047,-2048,2047,-2048,-2048,2047,-2048,0,0));
		rows.push_back(make_row(0, -2048,-2048,2047,-2048,2047,2047,-2048,2047,2047,-2048));
		rows.push_back(make_row(0, 2047,-2048,-2048,2047,2047,2047,-2048,-2048,-2048,2047));
		rows.push_back(make_row(1, 2047,2047,-2048,-2048,-2048,-2048,2047,2047,2047,-2048));
		rows.push_back(make_row(1, -2048,2047,2047,-2048,2047,-2048,-2048,2047,-2048,-2048));
		rows.push_back(make_row(1, 1,0,0,1,-1,0,0,1,0,2));
		rows.push_back(make_row(1, 0,0,0,0,5,5,1,0,3,-7));   // zero tangent direction
		rows.push_back(make_row(0, 0,0,1,1,2,2,3,3,4,5));    // collinear points
		rows.push_back(make_row(0, -1,-1,-1,-1,-1,-1,-1,-1,-1,-1));
		rows.push_back(make_row(1, 2047,2047,2047,2047,2047,2047,2047,2047,2047,2047));

		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (rows[i]) begin
			send_item(rows[i].op, rows[i].c);
			if (rows[i].fixed)
				for (int k = 0; k < 6; k++) begin
					// hand-typed checks: zero numerator and denominator
					if (expected_words[expected_words.size()-6+k].den !== rows[i].den ||
						expected_words[expected_words.size()-6+k].degen !== rows[i].degen ||
						expected_words[expected_words.size()-6+k].hi !== 64'd0 ||
						expected_words[expected_words.size()-6+k].lo !== 64'd0)
						report("directed row prediction");
				end
		end
		start <= 0;

		// drain fully once before the random part
		while (expected_words.size() != 0) @(posedge clk);

		for (int n = 0; n < 250; n++) begin
			mode = $urandom_range(0, 3);
			for (int i = 0; i < 10; i++)
				case (mode)
					0: c[i] = 12'($urandom);
					1: c[i] = 12'(rc(8));
					2: c[i] = $urandom_range(0, 1) ? 12'h7ff : 12'h800;
					default: c[i] = 12'(rc(300));
				endcase
			if (n % 25 == 0) c[8:9] = c[0:1];   // degenerate denominators
			send_item(1'($urandom_range(0, 1)), c);
		end
		start <= 0;

		while (expected_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
`default_nettype wire
